### sv/sorted_matrix_staircase_search_core_assert.svh
// Assertion macros shared by the staircase search modules.
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_CORE_ASSERT_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTH

// Whenever ante holds, cons holds in the same cycle.
`define SMSS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("staircase search assertion failed");

// Whenever ante holds, cons holds in the following cycle.
`define SMSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("staircase search assertion failed");

// The expression never holds.
`define SMSS_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("staircase search assertion failed");

`else

`define SMSS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SMSS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define SMSS_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

### sv/smss_pkg.sv
package smss_pkg;

   // Fixed field widths of the request and response transfers.
   localparam int INDEX_W    = 2;
   localparam int WORD_W     = 32;
   localparam int POS_W      = 3;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;

   // Row and column reported when the key is not in the matrix (-1).
   localparam logic [POS_W-1:0] NOT_FOUND_POS = 3'b111;

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_SEARCH = 1'b1
   } req_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic start;
      logic step_left;
      logic step_down;
      logic finish_found;
      logic finish_miss;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic greater;
      logic col_first;
      logic row_last;
      logic rsp_busy;
   } status_type;

endpackage

### sv/smss_ram.sv
module smss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/smss_ctrl.sv
`include "sorted_matrix_staircase_search_core_assert.svh"

module smss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_kind,
   input  smss_pkg::status_type   status,
   output smss_pkg::cmd_type      cmd
);

   smss_pkg::state_type state_ff;
   smss_pkg::state_type state_in;
   logic                accept;
   logic                walk_done;
   logic [5:0]          cmd_bits;

   assign accept = req_tvalid && req_tready;

   // The walk ends on a match or when the next step would leave the matrix.
   assign walk_done = status.match ||
                      (status.greater && status.col_first) ||
                      (!status.greater && status.row_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smss_pkg::ST_IDLE: begin
            if (accept && req_kind == smss_pkg::REQ_SEARCH) begin
               state_in = smss_pkg::ST_WALK;
            end
         end
         smss_pkg::ST_WALK: begin
            if (walk_done && !status.rsp_busy) begin
               state_in = smss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smss_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         smss_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == smss_pkg::REQ_SEARCH) begin
                  cmd.start = 1'b1;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         smss_pkg::ST_WALK: begin
            if (walk_done) begin
               // A finished walk waits here while the previous result is unread.
               if (!status.rsp_busy) begin
                  cmd.finish_found = status.match;
                  cmd.finish_miss  = !status.match;
               end
            end else if (status.greater) begin
               cmd.step_left = 1'b1;
            end else begin
               cmd.step_down = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign cmd_bits = {cmd.wr_en, cmd.start, cmd.step_left, cmd.step_down,
                      cmd.finish_found, cmd.finish_miss};

   `SMSS_ASSERT_IMP(a_cmd_exclusive, clock, reset, 1'b1, $onehot0(cmd_bits))

endmodule

### sv/smss_dp.sv
`include "sorted_matrix_staircase_search_core_assert.svh"

module smss_dp #(
   parameter int ROWS        = 4,
   parameter int COLS        = 4,
   parameter int VALUE_WIDTH = 32,
   localparam int Depth = ROWS * COLS,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int RowW  = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int ColW  = (COLS > 1) ? $clog2(COLS) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  smss_pkg::cmd_type                     cmd,
   output smss_pkg::status_type                  status,
   input  logic [smss_pkg::INDEX_W-1:0]          req_row_index,
   input  logic [smss_pkg::INDEX_W-1:0]          req_col_index,
   input  logic signed [smss_pkg::WORD_W-1:0]    req_entry_value,
   input  logic signed [smss_pkg::WORD_W-1:0]    req_search_key,
   output logic                                  ram_wr_en,
   output logic [AddrW-1:0]                      ram_wr_addr,
   output logic [VALUE_WIDTH-1:0]                ram_wr_data,
   output logic                                  ram_rd_en,
   output logic [AddrW-1:0]                      ram_rd_addr,
   input  logic [VALUE_WIDTH-1:0]                ram_rd_data,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic                                  rsp_found,
   output logic signed [smss_pkg::POS_W-1:0]     rsp_found_row,
   output logic signed [smss_pkg::POS_W-1:0]     rsp_found_col
);

   logic [VALUE_WIDTH-1:0]        key_ff;
   logic [VALUE_WIDTH-1:0]        key_in;
   logic [RowW-1:0]               row_ff;
   logic [RowW-1:0]               row_in;
   logic [ColW-1:0]               col_ff;
   logic [ColW-1:0]               col_in;
   logic [AddrW-1:0]              addr_ff;
   logic [AddrW-1:0]              addr_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_found_ff;
   logic                          rsp_found_in;
   logic [smss_pkg::POS_W-1:0]    rsp_row_ff;
   logic [smss_pkg::POS_W-1:0]    rsp_row_in;
   logic [smss_pkg::POS_W-1:0]    rsp_col_ff;
   logic [smss_pkg::POS_W-1:0]    rsp_col_in;

   logic [VALUE_WIDTH+smss_pkg::WORD_W-1:0] entry_ext;
   logic [VALUE_WIDTH+smss_pkg::WORD_W-1:0] key_ext;
   logic [31:0]                   wr_lin;
   logic                          wr_in_range;
   logic [RowW+smss_pkg::POS_W-1:0] row_wide;
   logic [ColW+smss_pkg::POS_W-1:0] col_wide;

   // Both words are sign-extended from 32 bits, then kept at VALUE_WIDTH bits.
   assign entry_ext = {{VALUE_WIDTH{req_entry_value[smss_pkg::WORD_W-1]}}, req_entry_value};
   assign key_ext   = {{VALUE_WIDTH{req_search_key[smss_pkg::WORD_W-1]}}, req_search_key};

   // Writes outside the matrix are dropped.
   assign wr_in_range = (32'(req_row_index) < 32'(ROWS)) && (32'(req_col_index) < 32'(COLS));
   assign wr_lin      = 32'(req_row_index) * 32'(COLS) + 32'(req_col_index);
   assign ram_wr_en   = cmd.wr_en && wr_in_range;
   assign ram_wr_addr = wr_lin[AddrW-1:0];
   assign ram_wr_data = entry_ext[VALUE_WIDTH-1:0];

   assign ram_rd_en = cmd.start || cmd.step_left || cmd.step_down;

   // The next read address goes straight to the RAM so one entry is visited per cycle.
   always_comb begin
      key_in      = key_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      addr_in     = addr_ff;
      ram_rd_addr = addr_ff;
      if (cmd.start) begin
         key_in      = key_ext[VALUE_WIDTH-1:0];
         row_in      = '0;
         col_in      = ColW'(COLS - 1);
         addr_in     = AddrW'(COLS - 1);
         ram_rd_addr = AddrW'(COLS - 1);
      end else if (cmd.step_left) begin
         col_in      = col_ff - ColW'(1);
         addr_in     = addr_ff - AddrW'(1);
         ram_rd_addr = addr_ff - AddrW'(1);
      end else if (cmd.step_down) begin
         row_in      = row_ff + RowW'(1);
         addr_in     = addr_ff + AddrW'(COLS);
         ram_rd_addr = addr_ff + AddrW'(COLS);
      end
   end

   assign status.match     = (ram_rd_data == key_ff);
   assign status.greater   = ($signed(ram_rd_data) > $signed(key_ff));
   assign status.col_first = (col_ff == '0);
   assign status.row_last  = (row_ff == RowW'(ROWS - 1));
   assign status.rsp_busy  = rsp_valid_ff && !rsp_tready;

   assign row_wide = {{smss_pkg::POS_W{1'b0}}, row_ff};
   assign col_wide = {{smss_pkg::POS_W{1'b0}}, col_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      if (cmd.finish_found) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = 1'b1;
         rsp_row_in   = row_wide[smss_pkg::POS_W-1:0];
         rsp_col_in   = col_wide[smss_pkg::POS_W-1:0];
      end else if (cmd.finish_miss) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = 1'b0;
         rsp_row_in   = smss_pkg::NOT_FOUND_POS;
         rsp_col_in   = smss_pkg::NOT_FOUND_POS;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      addr_ff      <= addr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_found_row = rsp_row_ff;
   assign rsp_found_col = rsp_col_ff;

   `SMSS_ASSERT_NEVER(a_finish_while_busy, clock, reset, (cmd.finish_found || cmd.finish_miss) && rsp_valid_ff && !rsp_tready)
   `SMSS_ASSERT_IMP(a_addr_tracks_pos, clock, reset, cmd.step_left || cmd.step_down, 32'(addr_ff) == 32'(row_ff) * 32'(COLS) + 32'(col_ff))
   `SMSS_ASSERT_NEXT(a_found_loaded, clock, reset, cmd.finish_found, rsp_valid_ff && rsp_found_ff)

endmodule

### sv/sorted_matrix_staircase_search_core.sv
// Staircase search over a ROWS x COLS matrix sorted along rows and columns.
// Request channel (req_): tuser[0] selects the kind of transfer, 0 writes one
// entry at row_index/col_index, 1 searches for search_key. A write gives no
// response. A search starts at the top-right entry and visits one entry per
// cycle, moving left when the entry is greater than the key and down
// otherwise; it visits at most ROWS+COLS-1 entries. The walk rate is set by
// the single read port of the matrix RAM. The response is registered; the
// block returns to idle at the edge that raises rsp_tvalid, so the next
// request can be taken while the response is still offered.
// Response channel (rsp_): tuser[0] is found, tdata carries the row and column
// of the match, both -1 on a miss. A finished response waits in its register
// while rsp_tready is low; the block keeps taking writes and may start a new
// search, which holds at its end until the waiting response is taken.
// Reset clears the control state only; matrix entries are undefined until
// written, and a write outside the matrix is ignored.
module sorted_matrix_staircase_search_core #(
   parameter int ROWS        = 4,
   parameter int COLS        = 4,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // row_index[1:0], col_index[3:2], entry_value[35:4], search_key[67:36], zeros
   input  logic [smss_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type[0]
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // found_row[2:0], found_col[5:3], zeros
   output logic [smss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // found[0]
   output logic [0:0]                         rsp_tuser
);

   localparam int Depth = ROWS * COLS;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

   smss_pkg::cmd_type                      cmd;
   smss_pkg::status_type                   status;
   logic                                   ram_wr_en;
   logic [AddrW-1:0]                       ram_wr_addr;
   logic [VALUE_WIDTH-1:0]                 ram_wr_data;
   logic                                   ram_rd_en;
   logic [AddrW-1:0]                       ram_rd_addr;
   logic [VALUE_WIDTH-1:0]                 ram_rd_data;
   logic                                   rsp_found;
   logic signed [smss_pkg::POS_W-1:0]      rsp_found_row;
   logic signed [smss_pkg::POS_W-1:0]      rsp_found_col;

   smss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser[0]),
      .status     (status),
      .cmd        (cmd)
   );

   smss_dp #(
      .ROWS        (ROWS),
      .COLS        (COLS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_row_index   (req_tdata[1:0]),
      .req_col_index   (req_tdata[3:2]),
      .req_entry_value (req_tdata[35:4]),
      .req_search_key  (req_tdata[67:36]),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_found       (rsp_found),
      .rsp_found_row   (rsp_found_row),
      .rsp_found_col   (rsp_found_col)
   );

   smss_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (Depth)
   ) u_matrix_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tdata = {2'b00, rsp_found_col, rsp_found_row};
   assign rsp_tuser = rsp_found;

endmodule

### test/search_answer_checker.sv
`timescale 1ns / 100ps

module search_answer_checker #(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // row_index[1:0], col_index[3:2], entry_value[35:4], search_key[67:36], zeros
   input  logic [smss_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic [0:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // found_row[2:0], found_col[5:3], zeros
   input  logic [smss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found[0]
   input  logic [0:0]                      rsp_tuser,
   output int                              mismatch_count,
   output int                              answers_pending
);

   localparam int INDEX_W = smss_pkg::INDEX_W;
   localparam int WORD_W  = smss_pkg::WORD_W;
   localparam int POS_W   = smss_pkg::POS_W;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } search_answer_type;

   logic signed [WORD_W-1:0] mirror_grid [ROWS][COLS];
   search_answer_type        awaited_answers [$];
   search_answer_type        want;
   logic [INDEX_W-1:0]       wr_row;
   logic [INDEX_W-1:0]       wr_col;

   initial begin
      mismatch_count  = 0;
      answers_pending = 0;
   end

   task automatic report_mismatch(string what, int got, int wanted);
      $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, wanted);
      mismatch_count++;
   endtask

   // Walk from the top-right corner: left while the entry is greater than the
   // key, down otherwise, until a match or the walk leaves the matrix.
   function automatic search_answer_type staircase_walk(logic signed [WORD_W-1:0] key);
      search_answer_type ans;
      int                r;
      int                c;
      bit                done;
      ans.hit = 1'b0;
      ans.row = smss_pkg::NOT_FOUND_POS;
      ans.col = smss_pkg::NOT_FOUND_POS;
      r = 0;
      c = COLS - 1;
      done = 1'b0;
      while (!done && r < ROWS && c >= 0) begin
         if (mirror_grid[r][c] == key) begin
            ans.hit = 1'b1;
            ans.row = POS_W'(r);
            ans.col = POS_W'(c);
            done = 1'b1;
         end else if (mirror_grid[r][c] > key) begin
            c--;
         end else begin
            r++;
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         // A response finishing at this edge belongs to an older search, so it
         // is checked before a request taken at the same edge is absorbed.
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch("response with no search pending", rsp_tuser[0], 0);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_tuser[0] !== want.hit)
                  report_mismatch("found", rsp_tuser[0], want.hit);
               if (rsp_tdata[POS_W-1:0] !== want.row)
                  report_mismatch("found_row", rsp_tdata[POS_W-1:0], want.row);
               if (rsp_tdata[2*POS_W-1:POS_W] !== want.col)
                  report_mismatch("found_col", rsp_tdata[2*POS_W-1:POS_W], want.col);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == smss_pkg::REQ_WRITE) begin
               wr_row = req_tdata[INDEX_W-1:0];
               wr_col = req_tdata[2*INDEX_W-1:INDEX_W];
               if (wr_row < ROWS && wr_col < COLS)
                  mirror_grid[wr_row][wr_col] = req_tdata[2*INDEX_W +: WORD_W];
            end else begin
               awaited_answers.push_back(staircase_walk(req_tdata[2*INDEX_W+WORD_W +: WORD_W]));
            end
         end
      end
      answers_pending <= awaited_answers.size();
   end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int ROWS        = 4;
   localparam int COLS        = 4;
   localparam int ITEM_TARGET = 950;
   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 400;
   localparam int SETTLE      = 20;
   localparam int INDEX_W     = smss_pkg::INDEX_W;
   localparam int WORD_W      = smss_pkg::WORD_W;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [smss_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [0:0]                      req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [smss_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]                      rsp_tuser;

   int   mismatch_total;
   int   answers_pending;
   int   src_idle_pct  = 28;
   int   sink_idle_pct = 66;
   int   items_sent    = 0;
   logic long_hold_arm = 1'b0;

   // Stimulus-side copy of the matrix, used only to pick interesting keys.
   logic signed [WORD_W-1:0] shadow [ROWS][COLS];

   sorted_matrix_staircase_search_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   search_answer_checker #(.ROWS(ROWS), .COLS(COLS)) answer_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_total),
      .answers_pending (answers_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Result side: random back-pressure, plus one long hold-off once armed.
   initial begin : receiver
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic offer_item(smss_pkg::req_kind_type kind, logic [INDEX_W-1:0] row,
                             logic [INDEX_W-1:0] col, logic [WORD_W-1:0] value,
                             logic [WORD_W-1:0] key);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, key, value, col, row};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Fields unused by the request kind carry random junk.
   task automatic write_entry(int r, int c, logic [WORD_W-1:0] value);
      shadow[r][c] = value;
      offer_item(smss_pkg::REQ_WRITE, INDEX_W'(r), INDEX_W'(c), value, $urandom());
   endtask

   task automatic search_for(logic [WORD_W-1:0] key);
      offer_item(smss_pkg::REQ_SEARCH, INDEX_W'($urandom()), INDEX_W'($urandom()),
                 $urandom(), key);
   endtask

   // Sorting the values and laying them out row-major keeps every row and
   // every column ascending; the cells are then written in random order.
   task automatic load_sorted_grid(bit narrow);
      int vals  [$];
      int order [ROWS*COLS];
      int j;
      int tmp;
      for (int n = 0; n < ROWS*COLS; n++) begin
         if (narrow)
            vals.push_back(int'($urandom_range(40)) - 20);
         else
            vals.push_back(int'($urandom()));
         order[n] = n;
      end
      vals.sort();
      for (int n = ROWS*COLS - 1; n > 0; n--) begin
         j = $urandom_range(n);
         tmp = order[n];
         order[n] = order[j];
         order[j] = tmp;
      end
      for (int n = 0; n < ROWS*COLS; n++)
         write_entry(order[n] / COLS, order[n] % COLS, vals[order[n]]);
   endtask

   // Keys are mostly stored values or their neighbors; stray writes now and
   // then leave the matrix unsorted.
   task automatic search_round(int count);
      int                r;
      int                c;
      int                pick;
      logic [WORD_W-1:0] key;
      repeat (count) begin
         r = $urandom_range(ROWS-1);
         c = $urandom_range(COLS-1);
         pick = $urandom_range(99);
         if (pick < 50)
            key = shadow[r][c];
         else if (pick < 65)
            key = shadow[r][c] + 1;
         else if (pick < 80)
            key = shadow[r][c] - 1;
         else
            key = $urandom();
         search_for(key);
         if ($urandom_range(99) < 8)
            write_entry($urandom_range(ROWS-1), $urandom_range(COLS-1), $urandom());
      end
   endtask

   initial begin : stimulus
      int directed_vals [ROWS*COLS];
      directed_vals = '{32'h8000_0000, -5000, -100, -1, 0, 1, 7, 8, 100, 1000, 5000,
                        65536, 32'h0010_0000, 32'h4000_0000, 32'h7FFF_FFFE,
                        32'h7FFF_FFFF};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Every entry is written before the first search.
      for (int n = 0; n < ROWS*COLS; n++)
         write_entry(n / COLS, n % COLS, directed_vals[n]);
      search_for(-1);                 // match at the starting corner
      search_for(32'h8000_0000);      // smallest value, top-left corner
      search_for(32'h7FFF_FFFF);      // largest value
      search_for(0);
      search_for(6);                  // miss inside the matrix
      search_for(32'h8000_0001);      // walk falls off the left edge
      search_for(32'h7FFF_FFFD);      // walk falls off the bottom edge
      write_entry(1, 0, 32'h7FFF_FFFF);
      search_for(0);                  // unsorted matrix

      while (items_sent < ITEM_TARGET) begin
         if (items_sent < ITEM_TARGET / 3) begin
            src_idle_pct  = 28;
            sink_idle_pct = 66;
         end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            src_idle_pct  = 66;
            sink_idle_pct = 28;
         end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
            if (!long_hold_arm)
               long_hold_arm <= 1'b1;
         end
         load_sorted_grid($urandom_range(3) == 0);
         search_round($urandom_range(5, 25));
      end
      req_tvalid <= 1'b0;

      while (answers_pending != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (mismatch_total == 0 && answers_pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/smss_pkg.sv
sv/smss_ram.sv
sv/smss_ctrl.sv
sv/smss_dp.sv
sv/sorted_matrix_staircase_search_core.sv
test/search_answer_checker.sv
test/tb.sv
